### design/sdp_pkg.sv
package sdp_pkg;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int APB_AW = 3;
	localparam logic REG_NARROW_RANGE = 1'b0;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       is_empty;
		logic       last;
	} sdp_in_t;

	typedef struct packed {
		logic              ok;
		logic signed [63:0] value;
	} sdp_out_t;

	typedef enum logic [1:0] {
		TK_MINUS,
		TK_ZERO,
		TK_NONZERO,
		TK_OTHER
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [3:0] digit;
		logic       is_empty;
		logic       last;
	} sdp_tok_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_SIGN,
		PH_DIGIT
	} parse_phase_t;

endpackage

### design/sdp_front.sv
module sdp_front import sdp_pkg::*; (
	input  sdp_in_t  in_word,
	output sdp_tok_t tok
);

	always_comb begin
		tok.digit    = in_word.char_byte[3:0];
		tok.is_empty = in_word.is_empty;
		tok.last     = in_word.last;
		if (in_word.char_byte == CH_MINUS) begin
			tok.kind = TK_MINUS;
		end else if (in_word.char_byte == CH_ZERO) begin
			tok.kind = TK_ZERO;
		end else if (in_word.char_byte >= CH_ONE && in_word.char_byte <= CH_NINE) begin
			tok.kind = TK_NONZERO;
		end else begin
			tok.kind = TK_OTHER;
		end
	end

endmodule

### design/sdp_queue.sv
module sdp_queue import sdp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  sdp_tok_t push_tok,
	output logic     full,
	output logic     tok_valid,
	output sdp_tok_t tok,
	input  logic     pop
);

	sdp_tok_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign tok_valid = (cnt_q != '0);
	assign tok       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### design/sdp_back.sv
module sdp_back import sdp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     narrow_range,
	input  logic     tok_valid,
	input  sdp_tok_t tok,
	output logic     pop,
	output logic     out_valid,
	input  logic     out_stall,
	output sdp_out_t out_word
);

	// string accumulator
	parse_phase_t phase_q;
	logic         neg_q;
	logic [63:0]  mag_q;
	logic         only_zero_q;
	logic         failed_q;

	// finish stage
	logic         fin_v_s1;
	logic         fin_ok_s1;
	logic         fin_neg_s1;
	logic [63:0]  fin_mag_s1;

	logic         out_v_q;
	sdp_out_t     out_q;

	parse_phase_t phase_d;
	logic         neg_d;
	logic [63:0]  mag_d;
	logic         only_zero_d;
	logic         failed_d;
	logic [67:0]  mac;
	logic         ends;
	logic         out_free;
	logic         fin_free;
	logic         in_range;
	sdp_out_t     res;

	assign ends     = tok.is_empty | tok.last;
	assign out_free = !out_v_q || !out_stall;
	assign fin_free = !fin_v_s1 || out_free;
	assign pop      = tok_valid && (!ends || fin_free);

	assign mac = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {64'd0, tok.digit};

	always_comb begin
		phase_d     = phase_q;
		neg_d       = neg_q;
		mag_d       = mag_q;
		only_zero_d = only_zero_q;
		failed_d    = failed_q;
		if (!failed_q) begin
			unique case (phase_q)
				PH_START: begin
					unique case (tok.kind)
						TK_MINUS: begin
							neg_d   = 1'b1;
							phase_d = PH_SIGN;
						end
						TK_NONZERO: begin
							mag_d   = {60'd0, tok.digit};
							phase_d = PH_DIGIT;
						end
						TK_ZERO: begin
							only_zero_d = 1'b1;
							phase_d     = PH_DIGIT;
						end
						default: failed_d = 1'b1;
					endcase
				end
				PH_SIGN: begin
					if (tok.kind == TK_NONZERO) begin
						mag_d   = {60'd0, tok.digit};
						phase_d = PH_DIGIT;
					end else begin
						failed_d = 1'b1;
					end
				end
				default: begin
					// any digit after a lone zero, a non-digit, or overflow fails
					if (only_zero_q || tok.kind == TK_MINUS || tok.kind == TK_OTHER
					    || mac[67:64] != 4'd0) begin
						failed_d = 1'b1;
					end else begin
						mag_d = mac[63:0];
					end
				end
			endcase
		end
		if (tok.is_empty) begin
			failed_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			only_zero_q <= 1'b0;
			failed_q    <= 1'b0;
		end else if (pop) begin
			if (ends) begin
				phase_q     <= PH_START;
				neg_q       <= 1'b0;
				mag_q       <= '0;
				only_zero_q <= 1'b0;
				failed_q    <= 1'b0;
			end else begin
				phase_q     <= phase_d;
				neg_q       <= neg_d;
				mag_q       <= mag_d;
				only_zero_q <= only_zero_d;
				failed_q    <= failed_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s1 <= 1'b0;
		end else if (fin_free) begin
			fin_v_s1 <= pop && ends;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_free && pop && ends) begin
			fin_ok_s1  <= !failed_d && phase_d != PH_START && phase_d != PH_SIGN;
			fin_neg_s1 <= neg_d;
			fin_mag_s1 <= mag_d;
		end
	end

	always_comb begin
		if (fin_neg_s1) begin
			in_range = narrow_range
				? (fin_mag_s1[63:32] == '0 && (!fin_mag_s1[31] || fin_mag_s1[30:0] == '0))
				: (!fin_mag_s1[63] || fin_mag_s1[62:0] == '0);
		end else begin
			in_range = narrow_range ? (fin_mag_s1[63:31] == '0) : !fin_mag_s1[63];
		end
		res.ok    = fin_ok_s1 && in_range;
		res.value = !res.ok ? '0
			: fin_neg_s1 ? $signed(~fin_mag_s1 + 64'd1) : $signed(fin_mag_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= fin_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fin_v_s1) begin
			out_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign out_word  = out_q;

endmodule

### design/strict_decimal_to_int64_parser.sv
// Path: once the word carrying last (or the empty flag) is accepted, its token
// passes the queue, then the finish stage (fin_*_s1) and the output register.
// Throughput: one input word per cycle sustained while the queue is not full; the
// accumulator does one multiply-by-ten and add per popped token. Reset (arst_n low, asynchronous) clears
// the queue, the string state and both result stages; narrow_range resets to 0.
module strict_decimal_to_int64_parser import sdp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// input byte stream
	input  logic              in_valid,
	output logic              in_stall,
	input  sdp_in_t           in_word,
	// result stream
	output logic              out_valid,
	input  logic              out_stall,
	output sdp_out_t          out_word,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic     narrow_q;
	logic     q_full;
	logic     q_push;
	logic     q_pop;
	logic     tok_valid;
	sdp_tok_t front_tok;
	sdp_tok_t back_tok;

	// Single register at byte address 0; the word index is paddr[2].
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_NARROW_RANGE) ? {31'd0, narrow_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			narrow_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == REG_NARROW_RANGE) begin
			narrow_q <= pwdata[0];
		end
	end

	// Front: classify each byte into a token and push it into the queue.
	// Stall only when the queue is full, so input flows while results wait.
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	sdp_front u_front (
		.in_word (in_word),
		.tok     (front_tok)
	);

	// Short token queue: decouples byte intake from the accumulator.
	sdp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_tok  (front_tok),
		.full      (q_full),
		.tok_valid (tok_valid),
		.tok       (back_tok),
		.pop       (q_pop)
	);

	// Back: accumulate digits, then range check, sign and register the result.
	sdp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.narrow_range (narrow_q),
		.tok_valid    (tok_valid),
		.tok          (back_tok),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_word     (out_word)
	);

endmodule

### test/tb_top.sv
module tb_top;
	import sdp_pkg::*;

	localparam int LIMIT_CYCLES  = 500000;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [APB_AW-1:0] NARROW_ADDR = APB_AW'(4 * REG_NARROW_RANGE);
	localparam logic [63:0] TEN_SAFE_MAX = 64'h1999_9999_9999_9999;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	sdp_in_t           in_word;
	logic              out_valid;
	logic              out_stall;
	sdp_out_t          out_word;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	strict_decimal_to_int64_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Our own copy of the parser: register, per-string state, and the
	// results it has promised but the block has not yet delivered.
	logic         narrow_mode;
	parse_phase_t str_phase;
	logic         str_neg;
	logic [63:0]  str_mag;
	logic         str_only_zero;
	logic         str_failed;
	sdp_out_t     expected_results[$];

	int        errors;
	int        words_sent;
	int        cycle_count;
	bit        tx_quiet;
	bit        rx_quiet;
	bit        hold_req;
	logic [7:0] text_q[$];
	sdp_out_t  want;

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= 10)
			$display("mismatch: %s", msg);
	endfunction

	// Finish the current string: decide ok against the selected range,
	// queue the expected word, and return to the idle string state.
	function automatic void close_string();
		sdp_out_t    r;
		logic [63:0] lim;
		r = '0;
		if (!str_failed && str_phase == PH_DIGIT) begin
			if (str_neg)
				lim = narrow_mode ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000;
			else
				lim = narrow_mode ? 64'h0000_0000_7FFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
			if (str_mag <= lim) begin
				r.ok    = 1'b1;
				r.value = str_neg ? (~str_mag + 64'd1) : str_mag;
			end
		end
		expected_results.push_back(r);
		str_phase     = PH_START;
		str_neg       = 1'b0;
		str_mag       = '0;
		str_only_zero = 1'b0;
		str_failed    = 1'b0;
	endfunction

	// Advance the string state by one accepted byte.
	function automatic void take_char(logic [7:0] c);
		logic [63:0] d;
		if (str_failed)
			return;
		case (str_phase)
			PH_START: begin
				if (c == CH_MINUS) begin
					str_neg   = 1'b1;
					str_phase = PH_SIGN;
				end else if (c >= CH_ONE && c <= CH_NINE) begin
					str_mag   = 64'(c - CH_ZERO);
					str_phase = PH_DIGIT;
				end else if (c == CH_ZERO) begin
					str_only_zero = 1'b1;
					str_phase     = PH_DIGIT;
				end else begin
					str_failed = 1'b1;
				end
			end
			PH_SIGN: begin
				if (c >= CH_ONE && c <= CH_NINE) begin
					str_mag   = 64'(c - CH_ZERO);
					str_phase = PH_DIGIT;
				end else begin
					str_failed = 1'b1;
				end
			end
			default: begin
				// a lone leading zero takes nothing after it
				if (str_only_zero || c < CH_ZERO || c > CH_NINE) begin
					str_failed = 1'b1;
				end else begin
					d = 64'(c - CH_ZERO);
					if (str_mag > TEN_SAFE_MAX)
						str_failed = 1'b1;
					else if (str_mag * 64'd10 > ~64'd0 - d)
						str_failed = 1'b1;
					else
						str_mag = str_mag * 64'd10 + d;
				end
			end
		endcase
	endfunction

	function automatic void parse_word(sdp_in_t w);
		if (w.is_empty) begin
			// empty flag aborts whatever is in progress
			str_failed = 1'b1;
			close_string();
		end else begin
			take_char(w.char_byte);
			if (w.last)
				close_string();
		end
	endfunction

	// Offer one word, hold it until accepted, then idle for a random gap.
	task automatic send_word(input sdp_in_t w);
		int gap;
		int pick;
		in_word  <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		parse_word(w);
		words_sent++;
		pick = $urandom_range(0, 99);
		if (tx_quiet || pick < 65)
			gap = 0;
		else if (pick < 93)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_empty(input bit last_flag);
		sdp_in_t w;
		w.char_byte = 8'($urandom_range(0, 255));
		w.is_empty  = 1'b1;
		w.last      = last_flag;
		send_word(w);
	endtask

	// Send the text buffer as one string; an empty word is slipped in before
	// byte abort_at when that index is not negative.
	task automatic send_text(input int abort_at);
		sdp_in_t w;
		for (int i = 0; i < text_q.size(); i++) begin
			if (i == abort_at)
				send_empty(1'($urandom_range(0, 1)));
			w.char_byte = text_q[i];
			w.is_empty  = 1'b0;
			w.last      = (i == text_q.size() - 1);
			send_word(w);
		end
		text_q.delete();
	endtask

	function automatic void put_number(bit neg, logic [63:0] mag);
		logic [7:0]  digs[$];
		logic [63:0] rest;
		rest = mag;
		do begin
			digs.push_front(CH_ZERO + 8'(rest % 64'd10));
			rest = rest / 64'd10;
		end while (rest != 0);
		if (neg)
			text_q.push_back(CH_MINUS);
		foreach (digs[i])
			text_q.push_back(digs[i]);
	endfunction

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
		send_text(-1);
	endtask

	function automatic logic [63:0] pick_magnitude();
		int          pick;
		logic [63:0] base;
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			// land on or next to a range edge
			case ($urandom_range(0, 4))
				0: base = 64'h0000_0000_7FFF_FFFF;
				1: base = 64'h0000_0000_8000_0000;
				2: base = 64'h7FFF_FFFF_FFFF_FFFF;
				3: base = 64'h8000_0000_0000_0000;
				default: base = 64'hFFFF_FFFF_FFFF_FFFF;
			endcase
			return base + 64'($urandom_range(0, 4)) - 64'd2;
		end else if (pick < 6) begin
			return 64'($urandom_range(1, 999));
		end
		return {32'($urandom), 32'($urandom)} >> $urandom_range(0, 63);
	endfunction

	// Drop valid and wait until every promised result is back, plus the
	// pipeline depth, so the block is idle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= NARROW_ADDR;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		narrow_mode = data[0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_readback();
		logic [31:0] data;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= NARROW_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (data[0] !== narrow_mode)
			flag_error($sformatf("narrow_range readback exp %0b got %0b",
				narrow_mode, data[0]));
	endtask

	// Change the range mode only with the stream idle; random upper bits
	// in the write word must not matter.
	task automatic set_narrow(input bit mode);
		logic [31:0] data;
		wait_drained();
		data    = $urandom;
		data[0] = mode;
		apb_write(data);
		check_readback();
	endtask

	task automatic test_reset_value();
		check_readback();
	endtask

	task automatic test_special_cases();
		set_narrow(1'b0);
		send_str("0");
		send_str("-0");
		send_str("-");
		send_str("01");
		send_str("-01");
		send_str("7");
		send_str("-8");
		send_str("+1");
		send_str("1a9");
		send_empty(1'b1);
		send_empty(1'b0);
		// empty flag in the middle of "12"
		text_q.push_back(CH_ONE);
		text_q.push_back(CH_ONE + 8'd1);
		send_text(1);
		// extreme byte codes
		text_q.push_back(8'h00);
		send_text(-1);
		text_q.push_back(8'hFF);
		send_text(-1);
		text_q.push_back(CH_NINE);
		text_q.push_back(8'hFF);
		send_text(-1);
	endtask

	task automatic test_range_limits();
		for (int m = 0; m < 2; m++) begin
			set_narrow(m[0]);
			put_number(1'b0, 64'h0000_0000_7FFF_FFFF); send_text(-1);
			put_number(1'b1, 64'h0000_0000_8000_0000); send_text(-1);
			put_number(1'b0, 64'h0000_0000_8000_0000); send_text(-1);
			put_number(1'b1, 64'h0000_0000_8000_0001); send_text(-1);
			put_number(1'b0, 64'h7FFF_FFFF_FFFF_FFFF); send_text(-1);
			put_number(1'b1, 64'h8000_0000_0000_0000); send_text(-1);
			put_number(1'b0, 64'h8000_0000_0000_0000); send_text(-1);
			put_number(1'b0, 64'hFFFF_FFFF_FFFF_FFFF); send_text(-1);
			send_str("18446744073709551616");
		end
	endtask

	// Hold the receiver off long enough for the token queue to fill and
	// the input to stall, while strings keep coming.
	task automatic test_backpressure();
		set_narrow(1'($urandom_range(0, 1)));
		hold_req = 1'b1;
		repeat (60) begin
			put_number(1'($urandom_range(0, 1)), 64'($urandom_range(1, 9)));
			send_text(-1);
		end
	endtask

	// Pause the sender until all results are back between short bursts.
	task automatic test_drain_pause();
		repeat (4) begin
			repeat (4) begin
				put_number(1'($urandom_range(0, 1)), 64'($urandom_range(1, 99999)));
				send_text(-1);
			end
			wait_drained();
		end
	endtask

	task automatic random_string();
		int  kind;
		int  abort_at;
		bit  neg;
		kind     = $urandom_range(0, 99);
		abort_at = -1;
		neg      = 1'($urandom_range(0, 1));
		if (kind < 60) begin
			put_number(neg, pick_magnitude());
		end else if (kind < 70) begin
			// append extra digits, which can push past 64 bits
			put_number(neg, pick_magnitude());
			repeat ($urandom_range(1, 3))
				text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
		end else if (kind < 80) begin
			put_number(neg, pick_magnitude());
			case ($urandom_range(0, 2))
				0: text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
				1: text_q.push_front(CH_ZERO);
				default: text_q.push_front(8'($urandom_range(0, 255)));
			endcase
		end else if (kind < 90) begin
			repeat ($urandom_range(1, 6))
				text_q.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 95) begin
			send_empty(1'($urandom_range(0, 1)));
		end else begin
			put_number(neg, pick_magnitude());
			if (text_q.size() > 1)
				abort_at = $urandom_range(1, text_q.size() - 1);
			else
				abort_at = 0;
		end
		if (text_q.size() != 0)
			send_text(abort_at);
	endtask

	task automatic test_random();
		int stop;
		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 2)
				set_narrow(ph[0]);
			else
				set_narrow(1'($urandom_range(0, 1)));
			// one phase runs flat out on both sides
			tx_quiet = (ph == 3);
			rx_quiet = (ph == 3);
			stop = words_sent + 120;
			while (words_sent < stop)
				random_string();
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// Result checker: compare each accepted word with the oldest promise.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				flag_error($sformatf("unexpected word ok %0b value %0d",
					out_word.ok, out_word.value));
			end else begin
				want = expected_results.pop_front();
				if (out_word.ok !== want.ok)
					flag_error($sformatf("ok exp %0b got %0b", want.ok, out_word.ok));
				if (out_word.value !== want.value)
					flag_error($sformatf("value exp %0d got %0d",
						want.value, out_word.value));
			end
		end
	end

	// Receiver: random stall runs, a long counted hold-off on request, and
	// no stalls at all in quiet stretches.
	initial begin : receiver
		int run_left;
		int hold_left;
		int pick;
		run_left  = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (rx_quiet) begin
				out_stall <= 1'b0;
				run_left = 0;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					out_stall <= 1'b0;
					run_left = $urandom_range(0, 7);
				end else if (pick < 62) begin
					out_stall <= 1'b0;
					run_left = $urandom_range(20, 60);
				end else if (pick < 95) begin
					out_stall <= 1'b1;
					run_left = $urandom_range(0, 2);
				end else begin
					out_stall <= 1'b1;
					run_left = $urandom_range(10, 40);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		errors        = 0;
		words_sent    = 0;
		cycle_count   = 0;
		tx_quiet      = 1'b0;
		rx_quiet      = 1'b0;
		hold_req      = 1'b0;
		narrow_mode   = 1'b0;
		str_phase     = PH_START;
		str_neg       = 1'b0;
		str_mag       = '0;
		str_only_zero = 1'b0;
		str_failed    = 1'b0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_word  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_value();
		test_special_cases();
		test_range_limits();
		test_backpressure();
		test_drain_pause();
		test_random();

		wait_drained();
		if (expected_results.size() != 0)
			flag_error("results still outstanding at end");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
design/sdp_pkg.sv
design/sdp_front.sv
design/sdp_queue.sv
design/sdp_back.sv
design/strict_decimal_to_int64_parser.sv
test/tb_top.sv
